// ===== rtl/core/dsd_pkg.sv =====
package dsd_pkg;

  // Number of display positions driven per number
  localparam int unsigned NumDigits = 8;

  localparam int unsigned ValueW = 32;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned SegW   = 7;
  localparam int unsigned SegsW  = NumDigits * SegW;

  // floor(n * RecipTen / 2^RecipShift) == n / 10 for every 32-bit n
  localparam logic [ValueW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;
  localparam int unsigned       ProdW      = 2 * ValueW;

  typedef logic [SegW-1:0]  seg_t;
  typedef logic [SegsW-1:0] segs_t;

  // Word handed from one cell to the next
  typedef struct packed {
    logic [ValueW-1:0] rest;
    segs_t             segs;
  } cell_data_t;

  // No-decode pattern, a in bit 6 down to g in bit 0, decimal point off
  function automatic seg_t seg_of_digit(input logic [3:0] digit);
    seg_t seg;
    case (digit)
      4'd0: seg = 7'h7E;
      4'd1: seg = 7'h30;
      4'd2: seg = 7'h6D;
      4'd3: seg = 7'h79;
      4'd4: seg = 7'h33;
      4'd5: seg = 7'h5B;
      4'd6: seg = 7'h5F;
      4'd7: seg = 7'h70;
      4'd8: seg = 7'h7F;
      4'd9: seg = 7'h7B;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== rtl/core/dsd_in_if.sv =====
interface dsd_in_if;
  logic                       valid;
  logic                       ready;
  logic [dsd_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/dsd_out_if.sv =====
interface dsd_out_if;
  logic                      valid;
  logic                      ready;
  logic [dsd_pkg::AddrW-1:0] digit_address;
  logic [dsd_pkg::SegW-1:0]  segments;
  logic                      last;

  modport source (output valid, output digit_address, output segments, output last,
                  input ready);
  modport sink   (input valid, input digit_address, input segments, input last,
                  output ready);
endinterface

// ===== rtl/core/decimal_seven_segment_display_driver_top.sv =====
// Channel     Dir  Payload                                    Words per number
// word_in_i   in   value[31:0]                                1
// word_out_o  out  digit_address[3:0], segments[6:0], last    8 (positions 1..8)
//
// A number walks a chain of eight cells, one register per cell; each cell strips one decimal
// digit with a reciprocal multiply by ten and appends its segment pattern.
// The first word is offered once the number has passed the cells into the serializer, which
// then sends one word per cycle unless stalled, taking the next number as it sends the last.
// Reset clears only the valid flags and the position count; there is no clearing pass.
// An output stall holds the current word and backs the chain up cell by cell; the input
// keeps accepting while any cell is free, so up to nine numbers can be in flight.
module decimal_seven_segment_display_driver_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  dsd_in_if.sink          word_in_i,
  dsd_out_if.source       word_out_o
);

  // Handshake and data between neighbor cells; index 0 is the input side
  logic                valid_chain [0:dsd_pkg::NumDigits];
  logic                ready_chain [0:dsd_pkg::NumDigits];
  dsd_pkg::cell_data_t data_chain  [0:dsd_pkg::NumDigits];

  // Feed the first cell with the raw number and an empty pattern row
  assign valid_chain[0]      = word_in_i.valid;
  assign data_chain[0].rest  = word_in_i.value;
  assign data_chain[0].segs  = '0;
  assign word_in_i.ready     = ready_chain[0];

  // One cell per display position; the first never blanks its digit
  for (genvar g = 0; g < dsd_pkg::NumDigits; g++) begin : g_cell
    dsd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .first_i     (g == 0),
      .in_valid_i  (valid_chain[g]),
      .in_data_i   (data_chain[g]),
      .in_ready_o  (ready_chain[g]),
      .out_valid_o (valid_chain[g+1]),
      .out_data_o  (data_chain[g+1]),
      .out_ready_i (ready_chain[g+1])
    );
  end

  // Send the finished pattern row one position at a time, lowest first
  dsd_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_chain[dsd_pkg::NumDigits]),
    .in_segs_i   (data_chain[dsd_pkg::NumDigits].segs),
    .in_ready_o  (ready_chain[dsd_pkg::NumDigits]),
    .out_valid_o (word_out_o.valid),
    .out_ready_i (word_out_o.ready),
    .out_addr_o  (word_out_o.digit_address),
    .out_segs_o  (word_out_o.segments),
    .out_last_o  (word_out_o.last)
  );

endmodule

// ===== rtl/core/dsd_cell.sv =====
module dsd_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                first_i,
  input  logic                in_valid_i,
  input  dsd_pkg::cell_data_t in_data_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output dsd_pkg::cell_data_t out_data_o,
  input  logic                out_ready_i
);

  logic                        valid_q, valid_d;
  dsd_pkg::cell_data_t         data_q, data_d;
  logic [dsd_pkg::ProdW-1:0]   prod;
  logic [dsd_pkg::ValueW-1:0]  quot;
  logic [dsd_pkg::ValueW-1:0]  rem_wide;
  logic [3:0]                  digit;
  logic                        blank;
  dsd_pkg::seg_t               seg;

  // Divide by ten through the reciprocal, then recover the remainder
  assign prod     = dsd_pkg::ProdW'(in_data_i.rest) * dsd_pkg::ProdW'(dsd_pkg::RecipTen);
  assign quot     = dsd_pkg::ValueW'(prod >> dsd_pkg::RecipShift);
  assign rem_wide = in_data_i.rest - (quot << 3) - (quot << 1);
  assign digit    = rem_wide[3:0];

  // Blank every position above the first once nothing is left
  assign blank = !first_i && (in_data_i.rest == '0);
  assign seg   = blank ? '0 : dsd_pkg::seg_of_digit(digit);

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_ready_o) begin
      valid_d     = in_valid_i;
      data_d.rest = quot;
      data_d.segs = (in_data_i.segs >> dsd_pkg::SegW)
                  | (dsd_pkg::SegsW'(seg) << (dsd_pkg::SegsW - dsd_pkg::SegW));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/core/dsd_serializer.sv =====
module dsd_serializer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  dsd_pkg::segs_t             in_segs_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dsd_pkg::AddrW-1:0]  out_addr_o,
  output dsd_pkg::seg_t              out_segs_o,
  output logic                       out_last_o
);

  logic                       busy_q, busy_d;
  logic [dsd_pkg::AddrW-1:0]  pos_q, pos_d;
  dsd_pkg::segs_t             segs_q, segs_d;
  logic                       take;
  logic                       last;

  assign last       = (pos_q == dsd_pkg::AddrW'(dsd_pkg::NumDigits));
  assign take       = busy_q && out_ready_i;
  assign in_ready_o = !busy_q || (take && last);

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    segs_d = segs_q;
    if (in_valid_i && in_ready_o) begin
      // Load the next number's positions
      busy_d = 1'b1;
      pos_d  = dsd_pkg::AddrW'(1);
      segs_d = in_segs_i;
    end else if (take) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        pos_d  = pos_q + dsd_pkg::AddrW'(1);
        segs_d = segs_q >> dsd_pkg::SegW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= dsd_pkg::AddrW'(1);
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    segs_q <= segs_d;
  end

  assign out_valid_o = busy_q;
  assign out_addr_o  = pos_q;
  assign out_segs_o  = segs_q[dsd_pkg::SegW-1:0];
  assign out_last_o  = last;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q >= dsd_pkg::AddrW'(1)) &&
               (pos_q <= dsd_pkg::AddrW'(dsd_pkg::NumDigits)))
    else $error("digit position out of range");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last) |=> busy_q && (pos_q == $past(pos_q) + dsd_pkg::AddrW'(1)))
    else $error("position did not advance after a word was taken");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> busy_q && (pos_q == dsd_pkg::AddrW'(1)))
    else $error("new number did not start at position one");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> in_ready_o)
    else $error("idle serializer refused a number");

endmodule
